[rtl/ipr_pkg.sv]
package ipr_pkg;

    // default store geometry
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // register file geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DIM_W      = 9;
    localparam int SCALE_W    = 7;
    localparam int PIXEL_W    = 24;

    // largest enlargement factor
    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd2;

    // item operations
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // flags of one pull item on its way to the output register
    typedef struct packed {
        logic valid;
        logic is_padding;
        logic row_end;
        logic image_end;
    } pull_info_t;

endpackage

[rtl/ipr_store.sv]
module ipr_store
    import ipr_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF
)
(
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [PIXEL_W-1:0]                    wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [PIXEL_W-1:0]                    rd_data
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ipr_ctrl.sv]
module ipr_ctrl
    import ipr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  func,
    input  logic [PIXEL_W-1:0]    pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [PIXEL_W-1:0]    wr_data,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    output pull_info_t            info
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = WW + HW;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int WX = WW + 1;
    localparam int HX = HW + 1;

    // configuration registers
    logic [DIM_W-1:0]   in_width_reg, in_width_next;
    logic [DIM_W-1:0]   in_height_reg, in_height_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;

    // sequencing state
    logic [LW-1:0]      load_count_reg, load_count_next;
    logic               image_ready_reg, image_ready_next;
    logic [RW-1:0]      src_row_reg, src_row_next;
    logic [SCALE_W-1:0] row_repeat_reg, row_repeat_next;
    logic [CW-1:0]      src_col_reg, src_col_next;
    logic [SCALE_W-1:0] col_repeat_reg, col_repeat_next;
    logic [1:0]         pad_left_reg, pad_left_next;

    logic [WW-1:0]      w_c;
    logic [HW-1:0]      h_c;
    logic [SCALE_W-1:0] s_c;
    logic [HW-1:0]      mul_b;
    logic [PW-1:0]      prod;
    logic               room;
    logic [LW-1:0]      cnt_inc;
    logic               ready_after;
    logic [1:0]         w_lo;
    logic [1:0]         s_lo;
    logic [3:0]         ws_lo;
    logic [1:0]         bytes_mod;
    logic [1:0]         pad;
    logic               col_rep_last;
    logic               col_last;
    logic               row_rep_last;
    logic               row_last;
    logic               end_row;
    logic               end_image;

    // register values out of range are pulled into range
    always_comb
    begin
        if (in_width_reg == '0)
            w_c = WW'(1);
        else if (int'(in_width_reg) > MAX_WIDTH)
            w_c = WW'(MAX_WIDTH);
        else
            w_c = WW'(in_width_reg);

        if (in_height_reg == '0)
            h_c = HW'(1);
        else if (int'(in_height_reg) > MAX_HEIGHT)
            h_c = HW'(MAX_HEIGHT);
        else
            h_c = HW'(in_height_reg);

        if (scale_reg == '0)
            s_c = SCALE_W'(1);
        else if (scale_reg > SCALE_MAX)
            s_c = SCALE_MAX;
        else
            s_c = scale_reg;
    end

    // shared multiplier: image size on a load, row base on a pull
    assign mul_b = (func == FUNC_LOAD) ? h_c : HW'(src_row_reg);
    assign prod  = PW'(w_c) * PW'(mul_b);

    // load bookkeeping
    assign room        = PW'(load_count_reg) < prod;
    assign cnt_inc     = load_count_reg + LW'(1);
    assign ready_after = room ? (PW'(cnt_inc) >= prod) : 1'b1;

    // padding bytes per output row, from the low bits of width times scale
    assign w_lo      = 2'(w_c);
    assign s_lo      = 2'(s_c);
    assign ws_lo     = {2'b00, w_lo} * {2'b00, s_lo};
    assign bytes_mod = 2'(ws_lo * 4'd3);
    assign pad       = 2'(2'd0 - bytes_mod);

    // end of repeat runs and of source rows and columns
    assign col_rep_last = ({1'b0, col_repeat_reg} + 8'd1) >= {1'b0, s_c};
    assign row_rep_last = ({1'b0, row_repeat_reg} + 8'd1) >= {1'b0, s_c};
    assign col_last     = (WX'(src_col_reg) + WX'(1)) >= WX'(w_c);
    assign row_last     = (HX'(src_row_reg) + HX'(1)) >= HX'(h_c);

    // store ports
    assign wr_addr = AW'(load_count_reg);
    assign wr_data = pixel;
    assign rd_addr = AW'(prod + PW'(src_col_reg));

    // next state
    always_comb
    begin
        in_width_next    = in_width_reg;
        in_height_next   = in_height_reg;
        scale_next       = scale_reg;
        load_count_next  = load_count_reg;
        image_ready_next = image_ready_reg;
        src_row_next     = src_row_reg;
        row_repeat_next  = row_repeat_reg;
        src_col_next     = src_col_reg;
        col_repeat_next  = col_repeat_reg;
        pad_left_next    = pad_left_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        end_row          = 1'b0;
        end_image        = 1'b0;
        info             = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:  in_width_next  = DIM_W'(cfg_data);
                REG_IN_HEIGHT: in_height_next = DIM_W'(cfg_data);
                REG_SCALE:     scale_next     = SCALE_W'(cfg_data);
                default:       ;
            endcase
        end

        if (take && func == FUNC_LOAD && !image_ready_reg)
        begin
            // fill the store in raster order
            if (room)
            begin
                wr_en           = 1'b1;
                load_count_next = cnt_inc;
            end
            image_ready_next = ready_after;
        end
        else if (take && func == FUNC_PULL && image_ready_reg)
        begin
            info.valid = 1'b1;
            if (pad_left_reg != 2'd0)
            begin
                // zero padding byte
                info.is_padding = 1'b1;
                pad_left_next   = pad_left_reg - 2'd1;
                end_row         = (pad_left_reg == 2'd1);
            end
            else
            begin
                // pixel from the store, step along the row
                rd_en = 1'b1;
                if (col_rep_last)
                begin
                    col_repeat_next = '0;
                    if (col_last)
                    begin
                        src_col_next = '0;
                        if (pad == 2'd0)
                            end_row = 1'b1;
                        else
                            pad_left_next = pad;
                    end
                    else
                    begin
                        src_col_next = CW'(src_col_reg + CW'(1));
                    end
                end
                else
                begin
                    col_repeat_next = col_repeat_reg + SCALE_W'(1);
                end
            end

            // step down the image at the end of an output row
            if (end_row)
            begin
                if (row_rep_last)
                begin
                    row_repeat_next = '0;
                    if (row_last)
                        end_image = 1'b1;
                    else
                        src_row_next = RW'(src_row_reg + RW'(1));
                end
                else
                begin
                    row_repeat_next = row_repeat_reg + SCALE_W'(1);
                end
            end

            info.row_end   = end_row;
            info.image_end = end_image;

            // back to loading after the last item
            if (end_image)
            begin
                load_count_next  = '0;
                image_ready_next = 1'b0;
                src_row_next     = '0;
                row_repeat_next  = '0;
                src_col_next     = '0;
                col_repeat_next  = '0;
                pad_left_next    = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg    <= DIM_W'(1);
            in_height_reg   <= DIM_W'(1);
            scale_reg       <= SCALE_W'(1);
            load_count_reg  <= '0;
            image_ready_reg <= 1'b0;
            src_row_reg     <= '0;
            row_repeat_reg  <= '0;
            src_col_reg     <= '0;
            col_repeat_reg  <= '0;
            pad_left_reg    <= '0;
        end
        else
        begin
            in_width_reg    <= in_width_next;
            in_height_reg   <= in_height_next;
            scale_reg       <= scale_next;
            load_count_reg  <= load_count_next;
            image_ready_reg <= image_ready_next;
            src_row_reg     <= src_row_next;
            row_repeat_reg  <= row_repeat_next;
            src_col_reg     <= src_col_next;
            col_repeat_reg  <= col_repeat_next;
            pad_left_reg    <= pad_left_next;
        end
    end

    // padding is only owed while an image is being sent
    a_pad_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pad_left_reg != 2'd0 |-> image_ready_reg)
        else $error("padding owed while no image is ready");

    // output position stays at the origin while loading
    a_origin_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
        !image_ready_reg |-> (src_row_reg == '0 && src_col_reg == '0
                              && row_repeat_reg == '0 && col_repeat_reg == '0))
        else $error("output position moved while loading");

    // a store write only happens on a load before the image is complete
    a_write_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (image_ready_reg || load_count_reg != '0))
        else $error("store write without load progress");

endmodule

[rtl/integer_pixel_replicate_upscaler_core.sv]
// pull items: address and multiplier are formed in the accepting cycle, the store read and
// the read stage are registered at the accepting edge, then the output register once it is free
// throughput: one item per cycle, loads and pulls alike; the input stalls only while
// the read stage holds an item and the output register is stalled
// reset clears counters and image state and sets width, height and scale to one;
// the pixel store is not cleared and holds unknown data until loaded
module integer_pixel_replicate_upscaler_core
    import ipr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            blue,
    input  logic [7:0]            green,
    input  logic [7:0]            red,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_blue,
    output logic [7:0]            out_green,
    output logic [7:0]            out_red,
    output logic                  is_padding,
    output logic                  row_end,
    output logic                  image_end,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               take;
    logic               advance;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [PIXEL_W-1:0] rd_data;
    pull_info_t         info;
    pull_info_t         rd_pend_reg, rd_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               is_padding_reg;
    logic               row_end_reg;
    logic               image_end_reg;

    // handshake: the read stage moves on whenever the output register is free
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = rd_pend_reg.valid && !advance;
    assign take     = in_valid && !in_stall;

    // sequencer
    ipr_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .func      (func),
        .pixel     ({red, green, blue}),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .info      (info)
    );

    // pixel store
    ipr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read stage and output register
    assign rd_pend_next   = in_stall ? rd_pend_reg : info;
    assign out_valid_next = advance ? rd_pend_reg.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, zero colours on a padding item
    always_ff @(posedge clk)
    begin
        if (advance && rd_pend_reg.valid)
        begin
            out_pixel_reg  <= rd_pend_reg.is_padding ? '0 : rd_data;
            is_padding_reg <= rd_pend_reg.is_padding;
            row_end_reg    <= rd_pend_reg.row_end;
            image_end_reg  <= rd_pend_reg.image_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_blue   = out_pixel_reg[7:0];
    assign out_green  = out_pixel_reg[15:8];
    assign out_red    = out_pixel_reg[23:16];
    assign is_padding = is_padding_reg;
    assign row_end    = row_end_reg;
    assign image_end  = image_end_reg;

    // the last item of an image also closes its row
    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && image_end_reg |-> row_end_reg)
        else $error("image end without row end");

    // padding items carry zero colours
    a_padding_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_padding_reg |-> out_pixel_reg == '0)
        else $error("padding item with non-zero colour");

    // a produced pull item always reaches the read stage
    a_pull_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        info.valid |=> rd_pend_reg.valid)
        else $error("pull item lost before the read stage");

    // a store read is issued only for a pixel item
    a_read_for_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (info.valid && !info.is_padding))
        else $error("store read without pixel item");

endmodule

[verif/integer_pixel_replicate_upscaler_core_test.sv]
module integer_pixel_replicate_upscaler_core_test
    import ipr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned ITEM_TARGET = 2000;

    // one output item as the block presents it
    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       is_padding;
        logic       row_end;
        logic       image_end;
    } upscaled_item_t;

    // predicts the enlarged image and checks each output item against it
    class upscale_scoreboard;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        logic [SCALE_W-1:0] scale_reg;
        logic [PIXEL_W-1:0] pixel_mem [STORE_DEPTH];
        int unsigned        loaded;
        int unsigned        row;
        int unsigned        row_rep;
        int unsigned        col;
        int unsigned        col_rep;
        int unsigned        pad_owed;
        bit                 image_ready;
        upscaled_item_t     expected_q [$];
        int unsigned        errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            scale_reg  = 1;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            loaded      = 0;
            image_ready = 1'b0;
            row         = 0;
            row_rep     = 0;
            col         = 0;
            col_rep     = 0;
            pad_owed    = 0;
        endfunction

        // zero acts as one, anything above the top acts as the top
        function int unsigned effective(int unsigned v, int unsigned top);
            if (v == 0)
                return 1;
            if (v > top)
                return top;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_IN_WIDTH:  width_reg  = data[DIM_W-1:0];
                REG_IN_HEIGHT: height_reg = data[DIM_W-1:0];
                REG_SCALE:     scale_reg  = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // returns 1 when the item stored a pixel or produced an output item
        function bit note_input(logic f, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned    w;
            int unsigned    h;
            int unsigned    s;
            int unsigned    total;
            int unsigned    pad;
            bit             stored;
            bit             row_done;
            bit             image_done;
            logic [23:0]    px;
            upscaled_item_t item;
            w          = effective(width_reg, MAX_WIDTH_DEF);
            h          = effective(height_reg, MAX_HEIGHT_DEF);
            s          = effective(scale_reg, SCALE_MAX);
            total      = w * h;
            pad        = (4 - ((w * s * 3) & 3)) & 3;
            stored     = 1'b0;
            row_done   = 1'b0;
            image_done = 1'b0;

            // loading: ignored once the image is complete
            if (f == FUNC_LOAD) begin
                if (image_ready)
                    return 1'b0;
                if (loaded < total) begin
                    pixel_mem[loaded % STORE_DEPTH] = {r, g, b};
                    loaded = (loaded + 1) & 32'h1FFFF;
                    stored = 1'b1;
                end
                if (loaded >= total)
                    image_ready = 1'b1;
                return stored;
            end

            if (!image_ready)
                return 1'b0;

            // padding owed for the current row, else the next replicated pixel
            if (pad_owed != 0) begin
                item.out_blue   = 8'h00;
                item.out_green  = 8'h00;
                item.out_red    = 8'h00;
                item.is_padding = 1'b1;
                pad_owed--;
                row_done = (pad_owed == 0);
            end else begin
                px = pixel_mem[(row * w + col) % STORE_DEPTH];
                item.out_blue   = px[7:0];
                item.out_green  = px[15:8];
                item.out_red    = px[23:16];
                item.is_padding = 1'b0;
                if (col_rep + 1 >= s) begin
                    col_rep = 0;
                    if (col + 1 >= w) begin
                        col = 0;
                        if (pad == 0)
                            row_done = 1'b1;
                        else
                            pad_owed = pad;
                    end else begin
                        col++;
                    end
                end else begin
                    col_rep++;
                end
            end

            // row and image bookkeeping
            if (row_done) begin
                if (row_rep + 1 >= s) begin
                    row_rep = 0;
                    if (row + 1 >= h)
                        image_done = 1'b1;
                    else
                        row++;
                end else begin
                    row_rep++;
                end
            end

            item.row_end   = row_done;
            item.image_end = image_done;
            expected_q.push_back(item);
            if (image_done)
                restart();
            return 1'b1;
        endfunction

        function void check_result(upscaled_item_t got);
            upscaled_item_t want;
            if (expected_q.size() == 0) begin
                $error("output item with none expected: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_blue !== want.out_blue) begin
                $error("out_blue: expected %0h, got %0h", want.out_blue, got.out_blue);
                errors++;
            end
            if (got.out_green !== want.out_green) begin
                $error("out_green: expected %0h, got %0h", want.out_green, got.out_green);
                errors++;
            end
            if (got.out_red !== want.out_red) begin
                $error("out_red: expected %0h, got %0h", want.out_red, got.out_red);
                errors++;
            end
            if (got.is_padding !== want.is_padding) begin
                $error("is_padding: expected %0b, got %0b", want.is_padding, got.is_padding);
                errors++;
            end
            if (got.row_end !== want.row_end) begin
                $error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
                errors++;
            end
            if (got.image_end !== want.image_end) begin
                $error("image_end: expected %0b, got %0b", want.image_end, got.image_end);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_blue;
    logic [7:0]            out_green;
    logic [7:0]            out_red;
    logic                  is_padding;
    logic                  row_end;
    logic                  image_end;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    upscale_scoreboard sb = new();
    bit                in_calm;
    bit                out_calm;
    int unsigned       items_done;

    integer_pixel_replicate_upscaler_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .is_padding (is_padding),
        .row_end    (row_end),
        .image_end  (image_end),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // drive one item after a random gap and wait until it is taken
    task automatic send_item(input logic f, input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        blue     <= b;
        green    <= g;
        red      <= r;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.note_input(f, b, g, r))
            items_done++;
        @(negedge clk);
    endtask

    // hold the input off until every output item has come and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.set_reg(index, data);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] s);
        drain();
        write_reg(REG_IN_WIDTH, w);
        write_reg(REG_IN_HEIGHT, h);
        write_reg(REG_SCALE, s);
    endtask

    // load until the image is complete, with early pulls mixed in when noise is set
    task automatic load_image(input bit noise);
        while (!sb.image_ready) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_item(FUNC_PULL, rand_byte(), rand_byte(), rand_byte());
            send_item(FUNC_LOAD, rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    // pull output items, with stray loads mixed in when noise is set
    task automatic pull_image(input bit noise, input int unsigned max_pulls);
        int unsigned n;
        n = 0;
        while (sb.image_ready && n < max_pulls) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_item(FUNC_LOAD, rand_byte(), rand_byte(), rand_byte());
            send_item(FUNC_PULL, rand_byte(), rand_byte(), rand_byte());
            n++;
        end
    endtask

    task automatic run_image(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] s);
        configure(w, h, s);
        load_image(1'b1);
        pull_image(1'b1, 32'hFFFF_FFFF);
    endtask

    // output side: check each item, then stall for a random time
    initial
    begin
        upscaled_item_t got;
        int unsigned    gap;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.out_blue   = out_blue;
                got.out_green  = out_green;
                got.out_red    = out_red;
                got.is_padding = is_padding;
                got.row_end    = row_end;
                got.image_end  = image_end;
                sb.check_result(got);
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                gap = out_calm ? 0 : $urandom_range(0, 5);
                if (gap != 0) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned kind;
        int unsigned loads;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_LOAD;
        blue       = 8'h00;
        green      = 8'h00;
        red        = 8'h00;
        cfg_we     = 1'b0;
        cfg_index  = REG_IN_WIDTH;
        cfg_data   = '0;
        in_calm    = 1'b0;
        out_calm   = 1'b0;
        items_done = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: a single pixel plus one padding item
        send_item(FUNC_PULL, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_PULL, 8'hFF, 8'hFF, 8'hFF);

        // two pixels doubled: rows without padding
        configure(2, 1, 2);
        send_item(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_LOAD, 8'hA5, 8'h5A, 8'hFF);
        pull_image(1'b0, 32'hFFFF_FFFF);

        // three pixels across: three padding items per row
        configure(3, 1, 1);
        send_item(FUNC_LOAD, 8'h01, 8'h02, 8'h03);
        send_item(FUNC_LOAD, 8'hFE, 8'hFD, 8'hFC);
        send_item(FUNC_LOAD, 8'h80, 8'h40, 8'h20);
        pull_image(1'b0, 32'hFFFF_FFFF);

        // height shrinks part-way through loading: next load only completes the image
        configure(2, 2, 1);
        send_item(FUNC_LOAD, 8'h11, 8'h22, 8'h33);
        send_item(FUNC_LOAD, 8'h44, 8'h55, 8'h66);
        send_item(FUNC_LOAD, 8'h77, 8'h88, 8'h99);
        drain();
        write_reg(REG_IN_HEIGHT, 1);
        send_item(FUNC_LOAD, 8'hEE, 8'hEE, 8'hEE);
        pull_image(1'b0, 32'hFFFF_FFFF);

        // scale above the top: a full first row of the largest run, then cut short
        configure(1, 1, 127);
        load_image(1'b0);
        pull_image(1'b0, 101);
        drain();
        write_reg(REG_SCALE, 1);
        pull_image(1'b0, 32'hFFFF_FFFF);

        // extreme settings, out-of-range values included
        run_image(0, 0, 2);
        run_image(511, 1, 1);
        run_image(256, 2, 1);
        run_image(1, 511, 0);

        // random images, mostly small
        while (items_done < ITEM_TARGET) begin
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                // registers shrink while the image is being read out
                configure(4, 3, 2);
                load_image(1'b1);
                pull_image(1'b1, $urandom_range(1, 40));
                drain();
                write_reg(REG_IN_WIDTH, CFG_DATA_W'($urandom_range(1, 4)));
                write_reg(REG_IN_HEIGHT, CFG_DATA_W'($urandom_range(1, 3)));
                write_reg(REG_SCALE, CFG_DATA_W'($urandom_range(1, 3)));
                pull_image(1'b1, 32'hFFFF_FFFF);
            end else if (kind == 1) begin
                // registers shrink part-way through loading
                configure(CFG_DATA_W'($urandom_range(3, 6)), CFG_DATA_W'($urandom_range(2, 4)),
                          CFG_DATA_W'($urandom_range(1, 2)));
                loads = $urandom_range(1, 5);
                repeat (loads) send_item(FUNC_LOAD, rand_byte(), rand_byte(), rand_byte());
                drain();
                write_reg(REG_IN_WIDTH, 1);
                write_reg(REG_IN_HEIGHT, CFG_DATA_W'($urandom_range(1, loads)));
                load_image(1'b0);
                pull_image(1'b1, 32'hFFFF_FFFF);
            end else begin
                // kind 2 keeps the previous setting for a back-to-back image
                if (kind != 2) begin
                    if ($urandom_range(0, 7) == 0)
                        configure(CFG_DATA_W'($urandom_range(0, 511)),
                                  CFG_DATA_W'($urandom_range(0, 1)),
                                  CFG_DATA_W'($urandom_range(0, 1)));
                    else
                        configure(CFG_DATA_W'($urandom_range(1, 6)),
                                  CFG_DATA_W'($urandom_range(1, 4)),
                                  CFG_DATA_W'($urandom_range(1, 3)));
                end
                load_image(1'b1);
                pull_image(1'b1, 32'hFFFF_FFFF);
            end
        end

        // wait for the last items, then report
        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
